### rtl/core/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants for the quaternion vector rotation core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qvr_pkg;

    // Quaternion register format is fixed at signed 16 bits
    localparam int QUAT_WIDTH = 16;

    // Defaults for the top level parameters
    localparam int VEC_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF = 14;

    // Configuration channel widths
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = QUAT_WIDTH;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_X = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Y = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Z = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_W = CFG_INDEX_WIDTH'(3);

    // Rotation matrix entry: sum of quaternion products, doubled, needs two
    // guard bits over a plain product
    localparam int MAT_WIDTH = 2 * QUAT_WIDTH + 2;

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] x;
        logic signed [QUAT_WIDTH-1:0] y;
        logic signed [QUAT_WIDTH-1:0] z;
        logic signed [QUAT_WIDTH-1:0] w;
    } quat_t;

    typedef logic signed [MAT_WIDTH-1:0] mat_entry_t;

    // Row-major 3x3 matrix, entry (i,j) at index 3*i+j
    typedef mat_entry_t [8:0] mat_t;

endpackage

### rtl/core/qvr_if.sv
// ----------------------------------------------------------------------------
// qvr_if
// Valid/ready channels of the rotation core: vector in, result out, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qvr_vec_if #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] vec_x;
    logic signed [VEC_WIDTH-1:0] vec_y;
    logic signed [VEC_WIDTH-1:0] vec_z;

    modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
    modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface qvr_res_if #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] out_x;
    logic signed [VEC_WIDTH-1:0] out_y;
    logic signed [VEC_WIDTH-1:0] out_z;
    logic                        clipped;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output clipped, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input clipped, output ready);
endinterface

interface qvr_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [qvr_pkg::CFG_INDEX_WIDTH-1:0]  index;
    logic [qvr_pkg::CFG_DATA_WIDTH-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/qvr_cfg.sv
// ----------------------------------------------------------------------------
// qvr_cfg
// Quaternion register file, written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qvr_cfg #(
    parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    qvr_cfg_if.sink        cfg,
    output qvr_pkg::quat_t quat
);

    localparam int QW = qvr_pkg::QUAT_WIDTH;

    // Identity rotation: w = 1.0 in the fixed-point format, kept to QW bits
    localparam logic signed [QW-1:0] ROT_W_RESET = QW'(64'd1 << FRAC_BITS);

    logic signed [QW-1:0] rot_x_reg;
    logic signed [QW-1:0] rot_y_reg;
    logic signed [QW-1:0] rot_z_reg;
    logic signed [QW-1:0] rot_w_reg;

    // Accept every write beat
    assign cfg.ready = 1'b1;

    // Decode the index and load the addressed register; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg <= '0;
            rot_y_reg <= '0;
            rot_z_reg <= '0;
            rot_w_reg <= ROT_W_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                qvr_pkg::REG_ROT_X: rot_x_reg <= cfg.data;
                qvr_pkg::REG_ROT_Y: rot_y_reg <= cfg.data;
                qvr_pkg::REG_ROT_Z: rot_z_reg <= cfg.data;
                qvr_pkg::REG_ROT_W: rot_w_reg <= cfg.data;
                default:            ;
            endcase
        end
    end

    assign quat.x = rot_x_reg;
    assign quat.y = rot_y_reg;
    assign quat.z = rot_z_reg;
    assign quat.w = rot_w_reg;

endmodule

### rtl/core/qvr_matrix.sv
// ----------------------------------------------------------------------------
// qvr_matrix
// Two pipeline stages: quaternion products, then the 3x3 rotation matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qvr_matrix #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  qvr_pkg::quat_t              quat,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [VEC_WIDTH-1:0] in_x,
    input  logic signed [VEC_WIDTH-1:0] in_y,
    input  logic signed [VEC_WIDTH-1:0] in_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output qvr_pkg::mat_t               mat,
    output logic signed [VEC_WIDTH-1:0] out_x,
    output logic signed [VEC_WIDTH-1:0] out_y,
    output logic signed [VEC_WIDTH-1:0] out_z
);

    localparam int PW = 2 * qvr_pkg::QUAT_WIDTH;
    localparam int MW = qvr_pkg::MAT_WIDTH;

    typedef struct packed {
        logic signed [PW-1:0] ww;
        logic signed [PW-1:0] xx;
        logic signed [PW-1:0] yy;
        logic signed [PW-1:0] zz;
        logic signed [PW-1:0] xy;
        logic signed [PW-1:0] wz;
        logic signed [PW-1:0] xz;
        logic signed [PW-1:0] wy;
        logic signed [PW-1:0] yz;
        logic signed [PW-1:0] wx;
    } qprod_t;

    logic                        v1_reg;
    qprod_t                      prod_reg;
    qprod_t                      prod_next;
    logic signed [VEC_WIDTH-1:0] vx1_reg;
    logic signed [VEC_WIDTH-1:0] vy1_reg;
    logic signed [VEC_WIDTH-1:0] vz1_reg;

    logic                        v2_reg;
    qvr_pkg::mat_t               mat_reg;
    qvr_pkg::mat_t               mat_next;
    logic signed [VEC_WIDTH-1:0] vx2_reg;
    logic signed [VEC_WIDTH-1:0] vy2_reg;
    logic signed [VEC_WIDTH-1:0] vz2_reg;

    logic rdy1;
    logic rdy2;

    // Stage ready: a stage takes a beat when empty or when it drains
    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Form the ten distinct quaternion products
    always_comb
    begin
        prod_next.ww = quat.w * quat.w;
        prod_next.xx = quat.x * quat.x;
        prod_next.yy = quat.y * quat.y;
        prod_next.zz = quat.z * quat.z;
        prod_next.xy = quat.x * quat.y;
        prod_next.wz = quat.w * quat.z;
        prod_next.xz = quat.x * quat.z;
        prod_next.wy = quat.w * quat.y;
        prod_next.yz = quat.y * quat.z;
        prod_next.wx = quat.w * quat.x;
    end

    // Combine products into the rotation matrix
    always_comb
    begin
        mat_next[0] = MW'(prod_reg.ww) + MW'(prod_reg.xx) - MW'(prod_reg.yy)
                    - MW'(prod_reg.zz);
        mat_next[1] = (MW'(prod_reg.xy) - MW'(prod_reg.wz)) <<< 1;
        mat_next[2] = (MW'(prod_reg.xz) + MW'(prod_reg.wy)) <<< 1;
        mat_next[3] = (MW'(prod_reg.xy) + MW'(prod_reg.wz)) <<< 1;
        mat_next[4] = MW'(prod_reg.ww) - MW'(prod_reg.xx) + MW'(prod_reg.yy)
                    - MW'(prod_reg.zz);
        mat_next[5] = (MW'(prod_reg.yz) - MW'(prod_reg.wx)) <<< 1;
        mat_next[6] = (MW'(prod_reg.xz) - MW'(prod_reg.wy)) <<< 1;
        mat_next[7] = (MW'(prod_reg.yz) + MW'(prod_reg.wx)) <<< 1;
        mat_next[8] = MW'(prod_reg.ww) - MW'(prod_reg.xx) - MW'(prod_reg.yy)
                    + MW'(prod_reg.zz);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Load payload on a moving beat, hold it otherwise
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            prod_reg <= prod_next;
            vx1_reg  <= in_x;
            vy1_reg  <= in_y;
            vz1_reg  <= in_z;
        end
        if (rdy2 && v1_reg)
        begin
            mat_reg <= mat_next;
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
            vz2_reg <= vz1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign mat       = mat_reg;
    assign out_x     = vx2_reg;
    assign out_y     = vy2_reg;
    assign out_z     = vz2_reg;

    // A stalled beat stays in place in both stages
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !rdy1 |=> v1_reg && $stable(prod_reg) && $stable(vx1_reg))
        else $error("qvr_matrix: product stage lost a stalled beat");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !out_ready |=> v2_reg && $stable(mat_reg) && $stable(vz2_reg))
        else $error("qvr_matrix: matrix stage lost a stalled beat");

endmodule

### rtl/core/qvr_apply.sv
// ----------------------------------------------------------------------------
// qvr_apply
// Three pipeline stages: matrix-vector products, rounded sums, saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qvr_apply #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF,
    parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  qvr_pkg::mat_t               mat,
    input  logic signed [VEC_WIDTH-1:0] in_x,
    input  logic signed [VEC_WIDTH-1:0] in_y,
    input  logic signed [VEC_WIDTH-1:0] in_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [VEC_WIDTH-1:0] out_x,
    output logic signed [VEC_WIDTH-1:0] out_y,
    output logic signed [VEC_WIDTH-1:0] out_z,
    output logic                        clipped
);

    localparam int MW    = qvr_pkg::MAT_WIDTH;
    localparam int PRW   = MW + VEC_WIDTH;
    localparam int SHIFT = 2 * FRAC_BITS;
    // Sum of three products plus the rounding half, with headroom
    localparam int SW    = (PRW + 3 > SHIFT + 2) ? PRW + 3 : SHIFT + 2;

    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (SHIFT - 1);
    localparam logic signed [SW-1:0] LIM_HI = {{(SW - VEC_WIDTH + 1){1'b0}},
                                               {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] LIM_LO = ~LIM_HI;
    localparam logic signed [VEC_WIDTH-1:0] OUT_HI = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] OUT_LO = ~OUT_HI;

    logic signed [VEC_WIDTH-1:0] vin [3];

    logic                        v3_reg;
    logic signed [PRW-1:0]       prod_reg  [9];
    logic signed [PRW-1:0]       prod_next [9];

    logic                        v4_reg;
    logic signed [SW-1:0]        sum_reg  [3];
    logic signed [SW-1:0]        sum_next [3];

    logic                        o_valid_reg;
    logic signed [VEC_WIDTH-1:0] res_reg  [3];
    logic signed [VEC_WIDTH-1:0] res_next [3];
    logic                        clip_reg;
    logic                        clip_next;

    logic rdy3;
    logic rdy4;
    logic rdy5;

    // Stage ready chain back from the output register
    assign rdy5     = !o_valid_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    assign vin[0] = in_x;
    assign vin[1] = in_y;
    assign vin[2] = in_z;

    // Multiply each matrix entry by its vector component
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[3 * i + j] = mat[3 * i + j] * vin[j];
            end
        end
    end

    // Sum each row and add half an LSB of the output for rounding
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = SW'(prod_reg[3 * i]) + SW'(prod_reg[3 * i + 1])
                        + SW'(prod_reg[3 * i + 2]) + HALF;
        end
    end

    // Drop the fraction (floor), then clamp to the output range
    always_comb
    begin
        logic signed [SW-1:0] r;
        clip_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            r = sum_reg[i] >>> SHIFT;
            if (r > LIM_HI)
            begin
                res_next[i] = OUT_HI;
                clip_next   = 1'b1;
            end
            else if (r < LIM_LO)
            begin
                res_next[i] = OUT_LO;
                clip_next   = 1'b1;
            end
            else
            begin
                res_next[i] = r[VEC_WIDTH-1:0];
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
            begin
                v3_reg <= in_valid;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                o_valid_reg <= v4_reg;
            end
        end
    end

    // Load payload on a moving beat, hold it otherwise
    always_ff @(posedge clk)
    begin
        if (rdy3 && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (rdy4 && v3_reg)
        begin
            sum_reg <= sum_next;
        end
        if (rdy5 && v4_reg)
        begin
            res_reg  <= res_next;
            clip_reg <= clip_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign clipped   = clip_reg;

    // A clipped result has at least one component at a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && clip_reg |->
            (res_reg[0] == OUT_HI || res_reg[0] == OUT_LO ||
             res_reg[1] == OUT_HI || res_reg[1] == OUT_LO ||
             res_reg[2] == OUT_HI || res_reg[2] == OUT_LO))
        else $error("qvr_apply: clipped set with no component at a limit");

    // A stalled sum beat stays in place
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !rdy4 |=> v4_reg && $stable(sum_reg[0]) && $stable(sum_reg[2]))
        else $error("qvr_apply: sum stage lost a stalled beat");

endmodule

### rtl/core/quaternion_vector_rotation_core.sv
// Pipeline: five register stages between an accepted vector and its offered result.
// Throughput: one vector per cycle while the result side takes results, set by the fully pipelined multiplier stages.
// Stalls on the result side back up stage by stage without loss or repetition.
// Reset: clears all pipeline valid bits and loads the identity quaternion.
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_core
// Rotates signed 3-D vectors by a configured quaternion, saturating output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_vector_rotation_core #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF,
    parameter int FRAC_BITS = qvr_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    qvr_cfg_if.sink    cfg,
    qvr_vec_if.sink    vec,
    qvr_res_if.source  res
);

    qvr_pkg::quat_t              quat;
    qvr_pkg::mat_t               mat;
    logic                        mat_valid;
    logic                        mat_ready;
    logic signed [VEC_WIDTH-1:0] mat_vx;
    logic signed [VEC_WIDTH-1:0] mat_vy;
    logic signed [VEC_WIDTH-1:0] mat_vz;

    // Quaternion registers
    qvr_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .quat  (quat)
    );

    // Rotation matrix stages
    qvr_matrix #(
        .VEC_WIDTH (VEC_WIDTH)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .quat      (quat),
        .in_valid  (vec.valid),
        .in_ready  (vec.ready),
        .in_x      (vec.vec_x),
        .in_y      (vec.vec_y),
        .in_z      (vec.vec_z),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .mat       (mat),
        .out_x     (mat_vx),
        .out_y     (mat_vy),
        .out_z     (mat_vz)
    );

    // Matrix-vector product, rounding and saturation stages
    qvr_apply #(
        .VEC_WIDTH (VEC_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_apply (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .mat       (mat),
        .in_x      (mat_vx),
        .in_y      (mat_vy),
        .in_z      (mat_vz),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_x     (res.out_x),
        .out_y     (res.out_y),
        .out_z     (res.out_z),
        .clipped   (res.clipped)
    );

endmodule

### sim/quaternion_vector_rotation_core_test.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_core_test
// Streams signed vectors through the rotation core under random valid/ready
// gaps, reloads the quaternion between streams, and checks every result beat
// against an in-bench matrix predictor with half-up rounding and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_vector_rotation_core_test;

    localparam int VW             = qvr_pkg::VEC_WIDTH_DEF;
    localparam int FB             = qvr_pkg::FRAC_BITS_DEF;
    localparam int QW             = qvr_pkg::QUAT_WIDTH;
    localparam int IW             = qvr_pkg::CFG_INDEX_WIDTH;
    localparam int IDLE_PCT       = 27;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 125;

    // Indexes outside the register map; writes there must be dropped
    localparam logic [IW-1:0] REG_UNMAPPED_LO = qvr_pkg::REG_ROT_W + 1'b1;
    localparam logic [IW-1:0] REG_UNMAPPED_HI = '1;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } vec_beat_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic                 clip;
    } rot_result_t;

    logic clk;
    logic rst_n;

    qvr_cfg_if           cfg_ch ();
    qvr_vec_if #(.VEC_WIDTH(VW)) vec_ch ();
    qvr_res_if #(.VEC_WIDTH(VW)) res_ch ();

    quaternion_vector_rotation_core #(
        .VEC_WIDTH (VW),
        .FRAC_BITS (FB)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch.sink),
        .vec   (vec_ch.sink),
        .res   (res_ch.source)
    );

    // Bench copy of the orientation registers
    logic signed [QW-1:0] q_x;
    logic signed [QW-1:0] q_y;
    logic signed [QW-1:0] q_z;
    logic signed [QW-1:0] q_w;

    vec_beat_t   vec_q[$];
    rot_result_t rotated_q[$];

    bit steady;
    bit vec_fire;
    int errors;
    int vectors_sent;
    int results_checked;
    int clipped_seen;
    int reg_writes;
    int settings_used;
    int idle_cycles;

    // ------------------------------------------------------------------------
    // Predictor: build M(q) in Q.(2*FB), take exact dot products, round half
    // up, clamp to the output width
    // ------------------------------------------------------------------------
    function automatic rot_result_t rotate_vector(vec_beat_t b);
        longint      qx, qy, qz, qw;
        longint      m[3][3];
        longint      v[3];
        longint      acc;
        longint      lim_hi;
        longint      lim_lo;
        logic signed [VW-1:0] o[3];
        rot_result_t r;
        int          i;
        qx = q_x;
        qy = q_y;
        qz = q_z;
        qw = q_w;
        v[0] = b.x;
        v[1] = b.y;
        v[2] = b.z;
        lim_hi = (longint'(1) << (VW - 1)) - 1;
        lim_lo = -lim_hi - 1;
        m[0][0] = qw*qw + qx*qx - qy*qy - qz*qz;
        m[0][1] = 2 * (qx*qy - qw*qz);
        m[0][2] = 2 * (qx*qz + qw*qy);
        m[1][0] = 2 * (qx*qy + qw*qz);
        m[1][1] = qw*qw - qx*qx + qy*qy - qz*qz;
        m[1][2] = 2 * (qy*qz - qw*qx);
        m[2][0] = 2 * (qx*qz - qw*qy);
        m[2][1] = 2 * (qy*qz + qw*qx);
        m[2][2] = qw*qw - qx*qx - qy*qy + qz*qz;
        r.clip = 1'b0;
        for (i = 0; i < 3; i++)
        begin
            acc = m[i][0]*v[0] + m[i][1]*v[1] + m[i][2]*v[2];
            acc = (acc + (longint'(1) << (2*FB - 1))) >>> (2*FB);
            if (acc > lim_hi)
            begin
                acc    = lim_hi;
                r.clip = 1'b1;
            end
            if (acc < lim_lo)
            begin
                acc    = lim_lo;
                r.clip = 1'b1;
            end
            o[i] = acc[VW-1:0];
        end
        r.x = o[0];
        r.y = o[1];
        r.z = o[2];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Vector driver and result stall: advance on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        vec_beat_t b;
        // Hold the beat until it is taken, then offer the next one or idle
        if (!vec_ch.valid || vec_fire)
        begin
            if (vec_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                b = vec_q.pop_front();
                vec_ch.valid <= 1'b1;
                vec_ch.vec_x <= b.x;
                vec_ch.vec_y <= b.y;
                vec_ch.vec_z <= b.z;
            end
            else
            begin
                vec_ch.valid <= 1'b0;
            end
        end
        res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Monitor: predict accepted vectors, track register writes, check results
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        vec_beat_t   b;
        rot_result_t exp_r;
        bit          res_fire;
        bit          cfg_fire;
        vec_fire = vec_ch.valid && vec_ch.ready;
        res_fire = res_ch.valid && res_ch.ready;
        cfg_fire = cfg_ch.valid && cfg_ch.ready;

        // Mirror register writes; unmapped indexes are dropped
        if (cfg_fire)
        begin
            case (cfg_ch.index)
                qvr_pkg::REG_ROT_X: q_x = cfg_ch.data;
                qvr_pkg::REG_ROT_Y: q_y = cfg_ch.data;
                qvr_pkg::REG_ROT_Z: q_z = cfg_ch.data;
                qvr_pkg::REG_ROT_W: q_w = cfg_ch.data;
                default: ;
            endcase
            reg_writes++;
        end

        if (vec_fire)
        begin
            b.x = vec_ch.vec_x;
            b.y = vec_ch.vec_y;
            b.z = vec_ch.vec_z;
            rotated_q.push_back(rotate_vector(b));
            vectors_sent++;
        end

        if (res_fire)
        begin
            if (rotated_q.size() == 0)
            begin
                $error("result beat with no vector outstanding: %0d %0d %0d clipped=%0b",
                       res_ch.out_x, res_ch.out_y, res_ch.out_z, res_ch.clipped);
                errors++;
            end
            else
            begin
                exp_r = rotated_q.pop_front();
                results_checked++;
                if (res_ch.clipped)
                    clipped_seen++;
                if (res_ch.out_x !== exp_r.x)
                begin
                    $error("out_x mismatch: expected %0d, actual %0d", exp_r.x, res_ch.out_x);
                    errors++;
                end
                if (res_ch.out_y !== exp_r.y)
                begin
                    $error("out_y mismatch: expected %0d, actual %0d", exp_r.y, res_ch.out_y);
                    errors++;
                end
                if (res_ch.out_z !== exp_r.z)
                begin
                    $error("out_z mismatch: expected %0d, actual %0d", exp_r.z, res_ch.out_z);
                    errors++;
                end
                if (res_ch.clipped !== exp_r.clip)
                begin
                    $error("clipped mismatch: expected %0b, actual %0b",
                           exp_r.clip, res_ch.clipped);
                    errors++;
                end
            end
        end

        // Watchdog on cycles with no beat on any channel
        if (vec_fire || res_fire || cfg_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles, %0d results outstanding",
                     idle_cycles, rotated_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_vec(input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
                            input logic signed [VW-1:0] z);
        vec_beat_t b;
        b.x = x;
        b.y = y;
        b.z = z;
        vec_q.push_back(b);
    endtask

    // Wait until every queued vector has been taken and every result checked
    task automatic wait_drained();
        do @(posedge clk);
        while (vec_q.size() != 0 || vec_ch.valid || rotated_q.size() != 0);
    endtask

    task automatic write_rot_reg(input logic [IW-1:0] idx,
                                 input logic [qvr_pkg::CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drain the pipe, then load all four quaternion components
    task automatic load_rotation(input logic signed [QW-1:0] x,
                                 input logic signed [QW-1:0] y,
                                 input logic signed [QW-1:0] z,
                                 input logic signed [QW-1:0] w);
        wait_drained();
        write_rot_reg(qvr_pkg::REG_ROT_X, x);
        write_rot_reg(qvr_pkg::REG_ROT_Y, y);
        write_rot_reg(qvr_pkg::REG_ROT_Z, z);
        write_rot_reg(qvr_pkg::REG_ROT_W, w);
        settings_used++;
    endtask

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'sh4000;
            4:       return 16'shC000;
            default: return 16'sh0001;
        endcase
    endfunction

    function automatic logic signed [VW-1:0] random_field(input int mode);
        case (mode)
            0:       return VW'($urandom());
            1:       return VW'(int'($urandom_range(600)) - 300);
            default: return ($urandom_range(1) != 0) ? VW'($urandom()) : VW'(pick_extreme());
        endcase
    endfunction

    // Random orientation: full range, components within +/-0.5, or built from extremes
    task automatic random_rotation();
        logic signed [QW-1:0] c[4];
        int k;
        int mode;
        mode = $urandom_range(2);
        for (k = 0; k < 4; k++)
        begin
            case (mode)
                0:       c[k] = QW'($urandom());
                1:       c[k] = $signed(16'($urandom_range(16384))) - 16'sd8192;
                default: c[k] = pick_extreme();
            endcase
        end
        load_rotation(c[0], c[1], c[2], c[3]);
        // Now and then poke an unmapped index; the rotation must not change
        if ($urandom_range(2) == 0)
            write_rot_reg(($urandom_range(1) != 0) ? REG_UNMAPPED_HI
                          : IW'($urandom_range(REG_UNMAPPED_HI, REG_UNMAPPED_LO)),
                          qvr_pkg::CFG_DATA_WIDTH'($urandom()));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int p;
        int n;
        int mode;
        rst_n        = 1'b0;
        steady       = 1'b0;
        vec_fire     = 1'b0;
        errors       = 0;
        vectors_sent = 0;
        results_checked = 0;
        clipped_seen = 0;
        reg_writes   = 0;
        settings_used = 1;
        idle_cycles  = 0;
        q_x = '0;
        q_y = '0;
        q_z = '0;
        q_w = 16'sd1 <<< FB;
        vec_ch.valid = 1'b0;
        vec_ch.vec_x = '0;
        vec_ch.vec_y = '0;
        vec_ch.vec_z = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Identity after reset: vectors pass through untouched
        push_vec(16'sd0, 16'sd0, 16'sd0);
        push_vec(16'sh7FFF, 16'sh8000, 16'sd1);
        push_vec(16'sh8000, 16'sh7FFF, -16'sd1);
        push_vec(16'sd12345, -16'sd23456, 16'sd345);

        // Quarter turn about z
        load_rotation(16'sd0, 16'sd0, 16'sd11585, 16'sd11585);
        push_vec(16'sd1000, 16'sd0, 16'sd0);
        push_vec(16'sd0, 16'sh7FFF, 16'sd0);
        push_vec(16'sh8000, 16'sh8000, 16'sh7FFF);

        // Half-length scalar quaternion scales by 1/4: exact halves round up
        load_rotation(16'sd0, 16'sd0, 16'sd0, 16'sd8192);
        push_vec(16'sd2, -16'sd2, 16'sd6);
        push_vec(-16'sd6, 16'sd3, 16'sd1);
        push_vec(16'sh7FFF, 16'sh8000, -16'sd1);

        // Unmapped indexes must leave the quarter-scale rotation in place
        wait_drained();
        write_rot_reg(REG_UNMAPPED_LO, 16'sh7FFF);
        write_rot_reg(REG_UNMAPPED_HI, 16'sh1234);
        push_vec(16'sd10, -16'sd10, 16'sd14);

        // Scalar of -2 scales by 4: values just inside and beyond both clamp limits
        load_rotation(16'sd0, 16'sd0, 16'sd0, 16'sh8000);
        push_vec(16'sd8191, 16'sd8192, -16'sd8193);
        push_vec(-16'sd8192, -16'sd8193, 16'sd0);
        push_vec(16'sh7FFF, 16'sh8000, 16'sd100);

        // All components at the negative limit, then at the positive limit
        load_rotation(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        push_vec(16'sd1, 16'sd1, 16'sd1);
        push_vec(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        load_rotation(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        push_vec(16'sd1, -16'sd1, 16'sd0);
        push_vec(16'sh8000, 16'sh7FFF, 16'sh8000);

        // Random streams, one orientation per stream; one stream runs unthrottled
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            random_rotation();
            steady = (p == 3);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                mode = $urandom_range(3);
                push_vec(random_field(mode), random_field(mode), random_field(mode));
            end
        end

        // Drain, then give stray beats time to show up
        wait_drained();
        steady = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Rotated %0d vectors under %0d orientations (%0d register writes), %0d saturated",
                 vectors_sent, settings_used, reg_writes, clipped_seen);
        $display("Checked %0d result beats, %0d outstanding, %0d mismatches",
                 results_checked, rotated_q.size(), errors);
        if (errors == 0 && rotated_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
rtl/core/qvr_pkg.sv
rtl/core/qvr_if.sv
rtl/core/qvr_cfg.sv
rtl/core/qvr_matrix.sv
rtl/core/qvr_apply.sv
rtl/core/quaternion_vector_rotation_core.sv
sim/quaternion_vector_rotation_core_test.sv
